// ----- sv/int4_scale_dequant_to_half_macros.svh -----
// ----------------------------------------------------------------------------
// int4_scale_dequant_to_half_macros
// Assertion macros shared by the dequantizer RTL.
// ----------------------------------------------------------------------------
`ifndef INT4_SCALE_DEQUANT_TO_HALF_MACROS_SVH
`define INT4_SCALE_DEQUANT_TO_HALF_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define I4DQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define I4DQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/i4dq_pkg.sv -----
// ----------------------------------------------------------------------------
// i4dq_pkg
// Types and constants of the int4 weight to binary16 dequantizer.
// ----------------------------------------------------------------------------
package i4dq_pkg;

    localparam logic [7:0]  NIB_MASK    = 8'h0f;
    localparam logic [4:0]  NIB_RANGE   = 5'd16;
    localparam logic [3:0]  NIB_NEG_MIN = 4'd8;
    localparam logic [7:0]  F32_EXP_MAX = 8'hff;
    localparam logic [14:0] HALF_INF    = 15'h7c00;
    localparam logic [15:0] HALF_QNAN   = 16'h7e00;
    localparam logic [9:0]  HALF_QUIET  = 10'h200;

    // Magnitude with exponent: value = mag * 2^expo, or a finished special pattern.
    typedef struct packed {
        logic              special;
        logic [15:0]       spec_half;
        logic              rsign;
        logic signed [9:0] expo;
        logic [28:0]       mag;
    } mag_stage_t;

endpackage

// ----- sv/i4dq_in_if.sv -----
// ----------------------------------------------------------------------------
// i4dq_in_if
// Request channel carrying one packed weight byte and its scale.
// ----------------------------------------------------------------------------
interface i4dq_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packed_byte;
    logic        take_high;
    logic [31:0] scale_bits;

    modport source (output valid, packed_byte, take_high, scale_bits, input ready);
    modport sink   (input valid, packed_byte, take_high, scale_bits, output ready);
endinterface

// ----- sv/i4dq_out_if.sv -----
// ----------------------------------------------------------------------------
// i4dq_out_if
// Result channel carrying one binary16 pattern.
// ----------------------------------------------------------------------------
interface i4dq_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_bits;

    modport source (output valid, half_bits, input ready);
    modport sink   (input valid, half_bits, output ready);
endinterface

// ----- sv/i4dq_round16.sv -----
// ----------------------------------------------------------------------------
// i4dq_round16
// Round a binary32-exact magnitude to binary16, nearest even, with IEEE
// subnormals and overflow to infinity.
// ----------------------------------------------------------------------------
module i4dq_round16 (
    input  i4dq_pkg::mag_stage_t stage,
    output logic [15:0]          half_bits
);
    import i4dq_pkg::*;

    logic [4:0]         len;
    logic signed [10:0] top;
    logic signed [10:0] qa;
    logic signed [10:0] q;
    logic signed [10:0] k;
    logic signed [10:0] qf;
    logic               big;
    logic [3:0]         lsh;
    logic [4:0]         ks;
    logic [29:0]        mag30;
    logic [29:0]        kept;
    logic [29:0]        remv;
    logic [29:0]        halfv;
    logic               up;
    logic [11:0]        m;
    logic [11:0]        mf;
    logic signed [10:0] fexp;

    // find the leading one
    always_comb
    begin
        len = 5'd0;
        for (int i = 0; i < 29; i++)
        begin
            if (stage.mag[i])
            begin
                len = 5'(i + 1);
            end
        end
    end

    // quantum exponent and drop count
    always_comb
    begin
        top = 11'(stage.expo) + $signed({6'b0, len});
        qa  = top - 11'sd11;
        q   = (qa < -11'sd24) ? -11'sd24 : qa;
        k   = q - 11'(stage.expo);
        big = top > 11'sd16;
        lsh = 4'(-k);
        ks  = (k > 11'sd30) ? 5'd30 : 5'(k);
    end

    // round to nearest even at the quantum
    always_comb
    begin
        mag30 = {1'b0, stage.mag};
        kept  = mag30 >> ks;
        remv  = mag30 & ((30'd1 << ks) - 30'd1);
        halfv = (ks == 5'd0) ? 30'd0 : (30'd1 << (ks - 5'd1));
        up    = (ks != 5'd0) && ((remv > halfv) || ((remv == halfv) && kept[0]));
        if (k < 11'sd0)
        begin
            m = {1'b0, stage.mag[10:0]} << lsh;
        end
        else
        begin
            m = kept[11:0] + {11'b0, up};
        end
        mf   = m[11] ? (m >> 1) : m;
        qf   = m[11] ? (q + 11'sd1) : q;
        fexp = qf + 11'sd25;
    end

    // pack the binary16 pattern
    always_comb
    begin
        if (stage.special)
        begin
            half_bits = stage.spec_half;
        end
        else if (big)
        begin
            half_bits = {stage.rsign, HALF_INF};
        end
        else if (mf == 12'd0)
        begin
            half_bits = {stage.rsign, 15'd0};
        end
        else if (qf > 11'sd5)
        begin
            half_bits = {stage.rsign, HALF_INF};
        end
        else if (mf < 12'd1024)
        begin
            half_bits = {stage.rsign, 5'd0, mf[9:0]};
        end
        else
        begin
            half_bits = {stage.rsign, fexp[4:0], mf[9:0]};
        end
    end

endmodule

// ----- sv/int4_scale_dequant_to_half.sv -----
// ----------------------------------------------------------------------------
// int4_scale_dequant_to_half
// Signed 4-bit weight times binary32 scale, rounded to binary32 and then to
// binary16, nearest even at both steps.
//
//   channel  dir  payload                               handshake
//   weight   in   packed_byte, take_high, scale_bits    valid/ready
//   result   out  half_bits                             valid/ready
//
// Two register stages: the input register, then decode, product, binary32
// rounding and binary16 rounding in one combinational pass into the result
// register. One request is taken every cycle unless a stalled result holds the input stage.
// A stalled result holds the input stage only once both stages are full.
// Reset clears the valid bits; the block is empty after reset.
// ----------------------------------------------------------------------------
`include "int4_scale_dequant_to_half_macros.svh"

module int4_scale_dequant_to_half (
    input logic       clk,
    input logic       rst_n,
    i4dq_in_if.sink   weight,
    i4dq_out_if.source result
);
    import i4dq_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg, s1_byte_next;
    logic        s1_high_reg, s1_high_next;
    logic [31:0] s1_scale_reg, s1_scale_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_half_reg, out_half_next;

    logic        s1_ready, out_ready;
    logic [15:0] rounded_half;
    mag_stage_t  prod_stage;
    mag_stage_t  round_stage;

    logic [3:0]  nib;
    logic        qneg;
    logic [3:0]  qmag;
    logic        ssign;
    logic [7:0]  sexp;
    logic [22:0] sman;
    logic        rsign;
    logic [23:0] sig;

    logic [2:0]  d;
    logic [28:0] p29;
    logic [28:0] kept;
    logic [28:0] remv;
    logic [28:0] halfv;
    logic        up;

    // stage readiness
    assign out_ready    = !out_valid_reg || result.ready;
    assign s1_ready     = !s1_valid_reg || out_ready;
    assign weight.ready = s1_ready;

    // hold the incoming request
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_byte_next  = s1_byte_reg;
        s1_high_next  = s1_high_reg;
        s1_scale_next = s1_scale_reg;
        if (s1_ready)
        begin
            s1_valid_next = weight.valid;
            s1_byte_next  = weight.packed_byte;
            s1_high_next  = weight.take_high;
            s1_scale_next = weight.scale_bits;
        end
    end

    // decode the weight and scale, form the exact product
    always_comb
    begin
        nib   = s1_high_reg ? s1_byte_reg[7:4] : 4'(s1_byte_reg & NIB_MASK);
        qneg  = nib >= NIB_NEG_MIN;
        qmag  = qneg ? 4'(NIB_RANGE - {1'b0, nib}) : nib;
        ssign = s1_scale_reg[31];
        sexp  = s1_scale_reg[30:23];
        sman  = s1_scale_reg[22:0];
        rsign = ssign ^ qneg;
        sig   = (sexp == 8'd0) ? {1'b0, sman} : {1'b1, sman};

        prod_stage.rsign     = rsign;
        prod_stage.mag       = {1'b0, 28'(sig) * 28'(qmag)};
        prod_stage.expo      = (sexp == 8'd0) ? -10'sd149 :
                               ($signed({2'b0, sexp}) - 10'sd150);
        prod_stage.special   = 1'b1;
        prod_stage.spec_half = {rsign, 15'd0};
        if (sexp == F32_EXP_MAX && sman != 23'd0)
        begin
            prod_stage.spec_half = {ssign, HALF_INF[14:10], sman[22:13] | HALF_QUIET};
        end
        else if (sexp == F32_EXP_MAX)
        begin
            prod_stage.spec_half = (qmag == 4'd0) ? HALF_QNAN : {rsign, HALF_INF};
        end
        else if (qmag == 4'd0)
        begin
            prod_stage.spec_half = {ssign, 15'd0};
        end
        else if (sexp == 8'd0 && sman == 23'd0)
        begin
            prod_stage.spec_half = {rsign, 15'd0};
        end
        else
        begin
            prod_stage.special = 1'b0;
        end
    end

    // round the product to 24 significant bits
    always_comb
    begin
        p29 = prod_stage.mag;
        if (p29[27])
        begin
            d = 3'd4;
        end
        else if (p29[26])
        begin
            d = 3'd3;
        end
        else if (p29[25])
        begin
            d = 3'd2;
        end
        else if (p29[24])
        begin
            d = 3'd1;
        end
        else
        begin
            d = 3'd0;
        end
        kept  = p29 >> d;
        remv  = p29 & ((29'd1 << d) - 29'd1);
        halfv = (d == 3'd0) ? 29'd0 : (29'd1 << (d - 3'd1));
        up    = (d != 3'd0) && ((remv > halfv) || ((remv == halfv) && kept[0]));

        round_stage     = prod_stage;
        round_stage.mag = (kept + {28'b0, up}) << d;
    end

    // round to binary16
    i4dq_round16 u_round16 (
        .stage     (round_stage),
        .half_bits (rounded_half)
    );

    // advance or hold the result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_half_next  = out_half_reg;
        if (out_ready)
        begin
            out_valid_next = s1_valid_reg;
            out_half_next  = rounded_half;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_byte_reg  <= s1_byte_next;
        s1_high_reg  <= s1_high_next;
        s1_scale_reg <= s1_scale_next;
        out_half_reg <= out_half_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.half_bits = out_half_reg;

    // a finite nonzero case always carries a nonzero product
    `I4DQ_ASSERT_IMP(a_prod_nonzero, s1_valid_reg && !prod_stage.special, prod_stage.mag != 29'd0, "zero product")
    // rounding never loses the magnitude
    `I4DQ_ASSERT_IMP(a_round_nonzero, s1_valid_reg && !round_stage.special, round_stage.mag != 29'd0, "zero rounded")
    // a stalled input stage keeps its request
    `I4DQ_ASSERT_NXT(a_s1_hold, s1_valid_reg && !out_ready, s1_valid_reg && $stable(s1_scale_reg), "input dropped")

endmodule
